### hw/rtl/gl2_dfr_term_score_assert.svh
// ----------------------------------------------------------------------------
// GL2 term score assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GL2_DFR_TERM_SCORE_ASSERT_SVH
`define GL2_DFR_TERM_SCORE_ASSERT_SVH
`ifndef SYNTHESIS
`define G2_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define G2_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define G2_ASSERT(lbl, clk, rst_n, prop, msg)
`define G2_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/gl2dfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GL2 term score package
// Widths, constants and shared types of the GL2 scoring pipeline.
// ----------------------------------------------------------------------------
package gl2dfr_pkg;
    localparam int X_W      = 41;   // widest log argument (cf + N)
    localparam int E_W      = 6;    // integer part of log2
    localparam int FRAC_W   = 32;   // log fraction bits
    localparam int LG_W     = E_W + FRAC_W;
    localparam int LN_W     = 37;   // natural log, 32 fraction bits
    localparam int TF_W     = 16;
    localparam int TFP_W    = TF_W + LN_W;
    localparam int NUM_W    = 59;
    localparam int DEN_W    = 54;
    localparam int Q_W      = 32;
    localparam int CFG_IDX_W = 1;
    localparam int LG2_LAT  = 35;
    localparam int LNR_LAT  = 3;
    localparam int TF_DLY   = LG2_LAT + LNR_LAT;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NDOCS = 1'b0,
        CFG_AVG   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;
endpackage

### hw/rtl/gl2_dfr_term_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GL2 divergence-from-randomness term score
// Fully pipelined per-posting GL2 score in unsigned Q8.24, saturating.
// ----------------------------------------------------------------------------
// Takes one posting per clock while o_in_stall is low and returns its score
// through the log2 lanes, the log ratio, the tf' products and numerator, the
// divider and the output register. Throughput is set by the five log2 lanes,
// which run one squaring per stage, and by the divider, which retires one
// quotient bit per stage; both are fully pipelined, so a transfer can be taken
// on every clock that o_in_stall is low. The whole pipe
// advances on one enable. While a result waits in the output register the
// pipe keeps moving, and keeps taking postings, until the next result drops
// into a one-entry skid behind the output register; o_in_stall then stays
// high until the sink takes the waiting result. N and the mean length are
// read when a posting is taken, so write them only while the block is drained.
`include "gl2_dfr_term_score_assert.svh"

module gl2_dfr_term_score import gl2dfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // posting input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [23:0]           i_doc_length,
    input  logic [TF_W-1:0]       i_term_freq,
    input  logic [39:0]           i_coll_freq,
    // score output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [Q_W-1:0]        o_score_q24,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    logic [31:0] r_ndocs, r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndocs <= 32'd1;
            r_avg   <= 32'd256;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NDOCS: r_ndocs <= i_cfg_data;
                CFG_AVG:   r_avg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipe enable: the whole pipe holds while the skid entry is full.
    logic      r_skid_valid;
    logic      w_en;
    t_pipe_ctl w_ctl;
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign w_ctl      = '{en: w_en, valid: i_in_valid};

    // Zero N, cf and len count as one.
    logic [31:0]    w_n;
    logic [39:0]    w_cf;
    logic [23:0]    w_len;
    logic [31:0]    w_len8;
    logic [X_W-1:0] w_xa, w_xb, w_xc, w_xd, w_xe;
    assign w_n    = (r_ndocs == '0) ? 32'd1 : r_ndocs;
    assign w_cf   = (i_coll_freq == '0) ? 40'd1 : i_coll_freq;
    assign w_len  = (i_doc_length == '0) ? 24'd1 : i_doc_length;
    assign w_len8 = {w_len, 8'b0};
    assign w_xa   = {1'b0, w_cf} + {9'b0, w_n};             // cf + N
    assign w_xb   = {9'b0, w_n};
    assign w_xc   = {1'b0, w_cf};
    assign w_xd   = {9'b0, w_len8} + {9'b0, r_avg};         // 256*len + avg
    assign w_xe   = {9'b0, w_len8};

    logic            w_va, w_vb, w_vc, w_vd, w_ve;
    logic [LG_W-1:0] w_la, w_lb, w_lc, w_ld, w_le;

    gl2dfr_lg2 u_lg_a (.i_clk, .i_rst_n, .i_ctl(w_ctl), .i_x(w_xa), .o_valid(w_va), .o_lg(w_la));
    gl2dfr_lg2 u_lg_b (.i_clk, .i_rst_n, .i_ctl(w_ctl), .i_x(w_xb), .o_valid(w_vb), .o_lg(w_lb));
    gl2dfr_lg2 u_lg_c (.i_clk, .i_rst_n, .i_ctl(w_ctl), .i_x(w_xc), .o_valid(w_vc), .o_lg(w_lc));
    gl2dfr_lg2 u_lg_d (.i_clk, .i_rst_n, .i_ctl(w_ctl), .i_x(w_xd), .o_valid(w_vd), .o_lg(w_ld));
    gl2dfr_lg2 u_lg_e (.i_clk, .i_rst_n, .i_ctl(w_ctl), .i_x(w_xe), .o_valid(w_ve), .o_lg(w_le));

    // left = ln((cf+N)/N), right = ln((cf+N)/cf), h = ln(1 + avg/(256*len))
    t_pipe_ctl       w_ctl_l, w_ctl_r, w_ctl_h;
    logic            w_vl, w_vr, w_vh;
    logic [LN_W-1:0] w_left, w_right, w_h;
    assign w_ctl_l = '{en: w_en, valid: w_va & w_vb};
    assign w_ctl_r = '{en: w_en, valid: w_va & w_vc};
    assign w_ctl_h = '{en: w_en, valid: w_vd & w_ve};

    gl2dfr_lnr u_ln_l (.i_clk, .i_rst_n, .i_ctl(w_ctl_l), .i_la(w_la), .i_lb(w_lb),
                       .o_valid(w_vl), .o_ln(w_left));
    gl2dfr_lnr u_ln_r (.i_clk, .i_rst_n, .i_ctl(w_ctl_r), .i_la(w_la), .i_lb(w_lc),
                       .o_valid(w_vr), .o_ln(w_right));
    gl2dfr_lnr u_ln_h (.i_clk, .i_rst_n, .i_ctl(w_ctl_h), .i_la(w_ld), .i_lb(w_le),
                       .o_valid(w_vh), .o_ln(w_h));

    // tf rides alongside the log pipes
    logic [TF_W-1:0] r_tf [0:TF_DLY-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tf[0] <= i_term_freq;
            for (int k = 1; k < TF_DLY; k++) r_tf[k] <= r_tf[k-1];
        end
    end

    // T1: tf' = tf * h
    logic             r1_v, r2_v, r3_v;
    logic [TFP_W-1:0] r1_tfp, r2_tfp;
    logic [LN_W-1:0]  r1_left, r1_right, r2_left;
    // T2: tf' * right in two partial products
    logic [68:0]      r2_pl;
    logic [57:0]      r2_ph;
    // T3: numerator and denominator
    logic [NUM_W-1:0] r3_num;
    logic [DEN_W-1:0] r3_den;
    logic [68:0]      n_pl;
    logic [57:0]      n_ph;
    logic [57:0]      n_mul;
    logic [NUM_W-1:0] n_num;
    logic [DEN_W-1:0] n_den;

    assign n_pl  = {37'b0, r1_tfp[31:0]} * {32'b0, r1_right};
    assign n_ph  = {37'b0, r1_tfp[TFP_W-1:32]} * {21'b0, r1_right};
    assign n_mul = {21'b0, r2_pl[68:32]} + r2_ph;
    assign n_num = {{(NUM_W-LN_W){1'b0}}, r2_left} + {1'b0, n_mul};
    assign n_den = {1'b0, r2_tfp} + (DEN_W'(1) << 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_vl & w_vr & w_vh;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_tfp   <= {{LN_W{1'b0}}, r_tf[TF_DLY-1]} * {{TF_W{1'b0}}, w_h};
            r1_left  <= w_left;
            r1_right <= w_right;
            r2_pl    <= n_pl;
            r2_ph    <= n_ph;
            r2_left  <= r1_left;
            r2_tfp   <= r1_tfp;
            r3_num   <= n_num;
            r3_den   <= n_den;
        end
    end

    t_pipe_ctl      w_ctl_d;
    logic           w_last_v;
    logic [Q_W-1:0] w_last_q;
    assign w_ctl_d = '{en: w_en, valid: r3_v};

    gl2dfr_div u_div (.i_clk, .i_rst_n, .i_ctl(w_ctl_d), .i_num(r3_num), .i_den(r3_den),
                      .o_valid(w_last_v), .o_score(w_last_q));

    // Output register with one skid entry behind it.
    logic           r_out_valid;
    logic [Q_W-1:0] r_out_q, r_skid_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_last_v;
            end
        end else if (w_last_v && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out_q <= r_skid_valid ? r_skid_q : w_last_q;
        end else if (w_last_v && !r_skid_valid) begin
            r_skid_q <= w_last_q;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score_q24 = r_out_q;

    `G2_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid full with empty output")
    `G2_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(i_out_stall), "skid filled without stall")
    `G2_ASSERT(a_hold_last, i_clk, i_rst_n, (!w_en && w_last_v) |=> w_last_v, "result lost while pipe held")
    `G2_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "reset left data")
endmodule

### hw/rtl/gl2dfr_lg2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GL2 log2 lane
// Pipelined log2 with 32 fraction bits: normalize, then one squaring a stage.
// ----------------------------------------------------------------------------
module gl2dfr_lg2 import gl2dfr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe_ctl        i_ctl,
    input  logic [X_W-1:0]   i_x,
    output logic             o_valid,
    output logic [LG_W-1:0]  o_lg
);
    logic [X_W-1:0]  r_x, r_x1;
    logic            r_v0, r_v1;
    logic [E_W-1:0]  r_e1;
    logic [E_W-1:0]  n_e;
    logic [X_W-1:0]  n_sh;
    logic [31:0]     r_m   [0:FRAC_W];
    logic [LG_W-1:0] r_res [0:FRAC_W];
    logic            r_v   [0:FRAC_W];

    // top set bit
    always_comb begin
        n_e = '0;
        for (int i = 0; i < X_W; i++) begin
            if (r_x[i]) n_e = E_W'(i);
        end
    end

    assign n_sh = r_x1 << (E_W'(X_W - 1) - r_e1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_v0   <= i_ctl.valid;
            r_v1   <= r_v0;
            r_v[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x      <= i_x;
            r_x1     <= r_x;
            r_e1     <= n_e;
            r_m[0]   <= n_sh[X_W-1 -: 32];
            r_res[0] <= {r_e1, {FRAC_W{1'b0}}};
        end
    end

    for (genvar k = 0; k < FRAC_W; k++) begin : g_it
        logic [63:0] n_sq;
        logic [32:0] n_s;
        assign n_sq = {32'b0, r_m[k]} * {32'b0, r_m[k]};
        assign n_s  = n_sq[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_m[k+1]   <= n_s[32] ? n_s[32:1] : n_s[31:0];
                r_res[k+1] <= r_res[k] | ({{(LG_W-1){1'b0}}, n_s[32]} << (FRAC_W - 1 - k));
            end
        end
    end

    assign o_valid = r_v[FRAC_W];
    assign o_lg    = r_res[FRAC_W];
endmodule

### hw/rtl/gl2dfr_lnr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GL2 log ratio
// ln(a/b) from two log2 values: clamp difference, scale by ln 2.
// ----------------------------------------------------------------------------
module gl2dfr_lnr import gl2dfr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe_ctl        i_ctl,
    input  logic [LG_W-1:0]  i_la,
    input  logic [LG_W-1:0]  i_lb,
    output logic             o_valid,
    output logic [LN_W-1:0]  o_ln
);
    logic [LG_W-1:0] r_d;
    logic [LG_W-1:0] r_pi;
    logic [31:0]     r_pf;
    logic [LN_W-1:0] r_ln;
    logic            r_v1, r_v2, r_v3;
    logic [63:0]     n_pf;
    logic [LG_W-1:0] n_pi;
    logic [LG_W:0]   n_sum;

    assign n_pf  = {32'b0, r_d[FRAC_W-1:0]} * {32'b0, LN2_Q32};
    assign n_pi  = {{FRAC_W{1'b0}}, r_d[LG_W-1:FRAC_W]} * {{E_W{1'b0}}, LN2_Q32};
    assign n_sum = {1'b0, r_pi} + {{(LG_W-31){1'b0}}, r_pf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d  <= (i_la > i_lb) ? i_la - i_lb : '0;
            r_pi <= n_pi;
            r_pf <= n_pf[63:32];
            r_ln <= n_sum[LN_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_ln    = r_ln;
endmodule

### hw/rtl/gl2dfr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GL2 score divider
// Saturating num * 2^24 / den, restoring division one quotient bit a stage.
// ----------------------------------------------------------------------------
module gl2dfr_div import gl2dfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_score
);
    logic [DEN_W-1:0] r_r   [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [7:0]       r_lo  [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic             r_sat [0:Q_W];
    logic             r_v   [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
        end
    end

    // quotient of 256 or more saturates
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sat[0] <= {3'b0, i_num} >= {i_den, 8'b0};
            r_r[0]   <= {3'b0, i_num[NUM_W-1:8]};
            r_lo[0]  <= i_num[7:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_st
        logic [DEN_W:0] n_r2;
        logic [DEN_W:0] n_df;
        logic           n_ge;
        assign n_r2 = {r_r[k], r_lo[k][7]};
        assign n_ge = n_r2 >= {1'b0, r_den[k]};
        assign n_df = n_r2 - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_r[k+1]   <= n_ge ? n_df[DEN_W-1:0] : n_r2[DEN_W-1:0];
                r_lo[k+1]  <= {r_lo[k][6:0], 1'b0};
                r_q[k+1]   <= {r_q[k][Q_W-2:0], n_ge};
                r_den[k+1] <= r_den[k];
                r_sat[k+1] <= r_sat[k];
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_score = r_sat[Q_W] ? '1 : r_q[Q_W];
endmodule

### dv/gl2_dfr_term_score_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GL2 term score testbench
// Drives postings through the scoring pipe under random idling and a long
// sink hold-off, predicts each score in fixed point and checks it in order.
// ----------------------------------------------------------------------------
module gl2_dfr_term_score_test;
    import gl2dfr_pkg::*;

    localparam int    PIPE_LAT  = 120;        // generous margin over the pipe depth
    localparam longint CYC_LIMIT = 400000;
    localparam logic [63:0] LN2_CONST = 64'h00000000B17217F8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [23:0]       i_doc_length = '0;
    logic [TF_W-1:0]   i_term_freq = '0;
    logic [39:0]       i_coll_freq = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [Q_W-1:0]    o_score_q24;
    logic              i_cfg_we = 1'b0;
    t_cfg_idx          i_cfg_index = CFG_NDOCS;
    logic [31:0]       i_cfg_data = '0;

    gl2_dfr_term_score u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [31:0] ndocs_reg = 32'd1;
    logic [31:0] avg_len_reg = 32'd256;

    logic [31:0] score_queue[$];
    int          err_count = 0;
    longint      cyc = 0;
    bit          idle_en = 1'b1;      // random bursts on both sides
    int          hold_cycles = 0;     // long sink hold-off request

    // log2 with 32 fraction bits by repeated squaring of the mantissa
    function automatic logic [63:0] log2_q32(logic [63:0] x);
        int          e;
        logic [63:0] m, res;
        logic [127:0] sq;
        e = 0;
        for (int b = 0; b < 64; b++)
            if (x[b]) e = b;
        if (x == 0) return 64'd0;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        res = 64'(e) << 32;
        for (int i = 31; i >= 0; i--) begin
            sq = 128'(m) * 128'(m);
            m = 64'(sq >> 31);
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] ln_of_ratio(logic [63:0] a, logic [63:0] b);
        logic [63:0]  la, lb, d;
        logic [127:0] p;
        la = log2_q32(a);
        lb = log2_q32(b);
        d = (la > lb) ? la - lb : 64'd0;
        p = 128'(d) * 128'(LN2_CONST);
        return 64'(p >> 32);
    endfunction

    function automatic logic [31:0] gl2_score(logic [23:0] len_in, logic [15:0] tf,
                                              logic [39:0] cf_in);
        logic [63:0]  n, cf, len, left, right, h, tfp, num, den, q;
        logic [127:0] prod;
        n = (ndocs_reg == 0) ? 64'd1 : 64'(ndocs_reg);
        cf = (cf_in == 0) ? 64'd1 : 64'(cf_in);
        len = (len_in == 0) ? 64'd1 : 64'(len_in);
        left = ln_of_ratio(cf + n, n);
        right = ln_of_ratio(n + cf, cf);
        h = ln_of_ratio((len << 8) + 64'(avg_len_reg), len << 8);
        tfp = 64'(tf) * h;
        prod = 128'(tfp) * 128'(right);
        num = left + 64'(prod >> 32);
        den = tfp + 64'h1_0000_0000;
        q = num / den;
        if (q >= 256) return 32'hFFFF_FFFF;
        return 32'((128'(num) << 24) / 128'(den));
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("gl2_dfr_term_score_test: done, errors");
            $finish;
        end
    end

    // sink: random stall bursts, plus a counted long hold-off on request
    initial begin : sink_stall
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                n = hold_cycles;
                hold_cycles = 0;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checker: every score transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (score_queue.size() == 0) begin
                $display("%0t: unexpected score, expected none, actual %h",
                         $time, o_score_q24);
                err_count++;
            end else begin
                if (o_score_q24 !== score_queue[0]) begin
                    $display("%0t: score_q24 mismatch, expected %h, actual %h",
                             $time, score_queue[0], o_score_q24);
                    err_count++;
                end
                void'(score_queue.pop_front());
            end
        end
    end

    // one posting transfer; prediction is taken at acceptance
    task automatic send_posting(logic [23:0] len, logic [15:0] tf, logic [39:0] cf);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_doc_length <= len;
        i_term_freq <= tf;
        i_coll_freq <= cf;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        score_queue.push_back(gl2_score(len, tf, cf));
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (score_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NDOCS) ndocs_reg = val;
        else avg_len_reg = val;
    endtask

    function automatic logic [39:0] rand_cf();
        case ($urandom_range(0, 3))
            0: return 40'($urandom_range(0, 20));
            1: return 40'($urandom);
            default: return {8'($urandom), 32'($urandom)} >> $urandom_range(0, 39);
        endcase
    endfunction

    function automatic logic [23:0] rand_len();
        if ($urandom_range(0, 3) == 0) return 24'($urandom_range(0, 16));
        return 24'($urandom) >> $urandom_range(0, 23);
    endfunction

    function automatic logic [15:0] rand_tf();
        if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 4));
        return 16'($urandom) >> $urandom_range(0, 15);
    endfunction

    // field extremes and the zero-valued special cases, at reset config and at zero and all-ones registers
    task automatic test_directed_extremes();
        send_posting(24'd1, 16'd0, 40'd1);
        send_posting(24'd0, 16'd5, 40'd0);          // zero len and zero cf
        send_posting(24'hFFFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF);
        send_posting(24'd1, 16'hFFFF, 40'd1);
        send_posting(24'hFFFFFF, 16'd1, 40'd1);
        send_posting(24'h555555, 16'hAAAA, 40'h55_5555_5555);
        send_posting(24'hAAAAAA, 16'h5555, 40'hAA_AAAA_AAAA);
        drain_pipe();
        write_reg(CFG_NDOCS, 32'd0);                 // zero N treated as one
        write_reg(CFG_AVG, 32'd0);                   // zero mean: score = left
        send_posting(24'd7, 16'd100, 40'd3);
        send_posting(24'd1, 16'hFFFF, 40'hFF_FFFF_FFFF);
        drain_pipe();
        write_reg(CFG_NDOCS, 32'hFFFF_FFFF);
        write_reg(CFG_AVG, 32'hFFFF_FFFF);
        send_posting(24'd1, 16'hFFFF, 40'd1);        // large right
        send_posting(24'd1, 16'd0, 40'd1);
        send_posting(24'hFFFFFF, 16'd3, 40'hFF_FFFF_FFFF);
        send_posting(24'd2, 16'd1, 40'd1);
        drain_pipe();
    endtask

    // random postings over a sweep of register settings
    task automatic test_random_sweep(int count);
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin write_reg(CFG_NDOCS, 32'd1); write_reg(CFG_AVG, 32'd256); end
                1: begin write_reg(CFG_NDOCS, 32'd1000000); write_reg(CFG_AVG, 32'd76800); end
                2: begin write_reg(CFG_NDOCS, 32'hFFFF_FFFF); write_reg(CFG_AVG, 32'd256); end
                default: begin
                    write_reg(CFG_NDOCS, $urandom);
                    write_reg(CFG_AVG, $urandom >> $urandom_range(0, 31));
                end
            endcase
            for (int i = 0; i < count / 6; i++)
                send_posting(rand_len(), rand_tf(), rand_cf());
            drain_pipe();
        end
    endtask

    // sink holds off while postings keep coming, filling the pipe
    task automatic test_backpressure_fill();
        hold_cycles = 300;
        for (int i = 0; i < 150; i++)
            send_posting(rand_len(), rand_tf(), rand_cf());
        drain_pipe();
    endtask

    // back-to-back postings with no idling on either side
    task automatic test_full_rate();
        idle_en = 1'b0;
        for (int i = 0; i < 100; i++)
            send_posting(rand_len(), rand_tf(), rand_cf());
        drain_pipe();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_random_sweep(480);
        test_backpressure_fill();
        test_full_rate();
        if (err_count == 0)
            $display("gl2_dfr_term_score_test: done, clean");
        else
            $display("gl2_dfr_term_score_test: done, errors");
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/gl2dfr_pkg.sv
hw/rtl/gl2dfr_lg2.sv
hw/rtl/gl2dfr_lnr.sv
hw/rtl/gl2dfr_div.sv
hw/rtl/gl2_dfr_term_score.sv
dv/gl2_dfr_term_score_test.sv
